// ----- rtl/oal_pkg.sv -----
// Shared types and constants for the ordered array list engine.
package oal_pkg;

  localparam int unsigned ACTION_BITS = 3;
  localparam int unsigned POS_BITS    = 10;
  localparam int unsigned VALUE_BITS  = 32;
  localparam int unsigned STATUS_BITS = 2;
  localparam int unsigned COUNT_BITS  = 11;

  typedef enum logic [ACTION_BITS-1:0] {
    ACT_APPEND    = 3'd0,
    ACT_INSERT    = 3'd1,
    ACT_DELETE    = 3'd2,
    ACT_OVERWRITE = 3'd3,
    ACT_SEARCH    = 3'd4,
    ACT_READ      = 3'd5
  } oal_action_e;

  typedef enum logic [STATUS_BITS-1:0] {
    STAT_OK    = 2'd0,
    STAT_FULL  = 2'd1,
    STAT_RANGE = 2'd2
  } oal_status_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_INS,
    ST_INS_PUT,
    ST_DEL,
    ST_SRCH,
    ST_DONE
  } oal_state_e;

  typedef struct packed {
    oal_status_e                    status;
    logic [COUNT_BITS-1:0]          entry_count;
    logic                           found;
    logic [POS_BITS-1:0]            found_position;
    logic signed [VALUE_BITS-1:0]   read_word;
  } oal_result_t;

endpackage

// ----- rtl/oal_ram.sv -----
// Entry store: one write port and one registered read port.
module oal_ram #(
  parameter int unsigned DEPTH     = 1024,
  parameter int unsigned WORD_BITS = 32,
  parameter int unsigned AW        = $clog2(DEPTH)
) (
  input  logic                 clk_i,
  input  logic                 we_i,
  input  logic [AW-1:0]        waddr_i,
  input  logic [WORD_BITS-1:0] wdata_i,
  input  logic                 re_i,
  input  logic [AW-1:0]        raddr_i,
  output logic [WORD_BITS-1:0] rdata_o
);

  logic [WORD_BITS-1:0] mem [DEPTH];
  logic [WORD_BITS-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ----- rtl/oal_ctrl.sv -----
// Action sequencer with the shared index, shift and compare datapath.
module oal_ctrl
  import oal_pkg::*;
#(
  parameter int unsigned DEPTH     = 1024,
  parameter int unsigned WORD_BITS = 32,
  parameter int unsigned AW        = $clog2(DEPTH),
  parameter int unsigned CW        = $clog2(DEPTH + 1)
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  output logic                         in_ready_o,
  input  logic [ACTION_BITS-1:0]       action_i,
  input  logic [POS_BITS-1:0]          position_i,
  input  logic signed [VALUE_BITS-1:0] value_i,
  output logic                         res_valid_o,
  input  logic                         res_ready_i,
  output oal_result_t                  res_o,
  output logic                         ram_we_o,
  output logic [AW-1:0]                ram_waddr_o,
  output logic [WORD_BITS-1:0]         ram_wdata_o,
  output logic                         ram_re_o,
  output logic [AW-1:0]                ram_raddr_o,
  input  logic [WORD_BITS-1:0]         ram_rdata_i
);

  localparam int unsigned XW = (CW > POS_BITS) ? CW : POS_BITS;

  oal_state_e           state_q, state_d;
  logic [CW-1:0]        count_q, count_d;
  logic [CW-1:0]        idx_q, idx_d;
  logic [XW-1:0]        pos_q, pos_d;
  logic [WORD_BITS-1:0] key_q, key_d;
  logic                 wv_q, wv_d;
  logic [AW-1:0]        wa_q, wa_d;
  logic                 cmp_v_q, cmp_v_d;
  logic [CW-1:0]        cmp_idx_q, cmp_idx_d;
  oal_status_e          status_q, status_d;
  logic                 found_q, found_d;
  logic [CW-1:0]        fpos_q, fpos_d;
  logic                 rd_sel_q, rd_sel_d;

  logic                 dwe;
  logic [AW-1:0]        dwaddr;
  logic [WORD_BITS-1:0] dwdata;
  logic signed [63:0]   val_ext;
  logic signed [63:0]   rd_ext;
  logic [WORD_BITS-1:0] word;
  logic [XW-1:0]        pos_x;
  logic [XW-1:0]        count_x;
  logic                 full;
  logic [CW-1:0]        idx_m1;
  logic [CW-1:0]        idx_p1;

  assign val_ext = 64'(value_i);
  assign word    = val_ext[WORD_BITS-1:0];
  assign rd_ext  = 64'(signed'(ram_rdata_i));
  assign pos_x   = XW'(position_i);
  assign count_x = XW'(count_q);
  assign full    = (count_q == CW'(DEPTH));
  assign idx_m1  = idx_q - 1'b1;
  assign idx_p1  = idx_q + 1'b1;

  always_comb begin
    state_d     = state_q;
    count_d     = count_q;
    idx_d       = idx_q;
    pos_d       = pos_q;
    key_d       = key_q;
    wv_d        = 1'b0;
    wa_d        = wa_q;
    cmp_v_d     = 1'b0;
    cmp_idx_d   = cmp_idx_q;
    status_d    = status_q;
    found_d     = found_q;
    fpos_d      = fpos_q;
    rd_sel_d    = rd_sel_q;
    dwe         = 1'b0;
    dwaddr      = '0;
    dwdata      = '0;
    ram_re_o    = 1'b0;
    ram_raddr_o = '0;
    in_ready_o  = 1'b0;
    res_valid_o = 1'b0;

    unique case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          status_d = STAT_OK;
          found_d  = 1'b0;
          fpos_d   = '0;
          rd_sel_d = 1'b0;
          key_d    = word;
          pos_d    = pos_x;
          state_d  = ST_DONE;
          unique case (oal_action_e'(action_i))
            ACT_APPEND: begin
              if (full) begin
                status_d = STAT_FULL;
              end else begin
                dwe     = 1'b1;
                dwaddr  = count_q[AW-1:0];
                dwdata  = word;
                count_d = count_q + 1'b1;
              end
            end
            ACT_INSERT: begin
              if (full) begin
                status_d = STAT_FULL;
              end else if (pos_x > count_x) begin
                status_d = STAT_RANGE;
              end else begin
                idx_d   = count_q;
                state_d = ST_INS;
              end
            end
            ACT_DELETE: begin
              if (pos_x >= count_x) begin
                status_d = STAT_RANGE;
              end else begin
                idx_d   = pos_x[CW-1:0];
                state_d = ST_DEL;
              end
            end
            ACT_OVERWRITE: begin
              if (pos_x >= count_x) begin
                status_d = STAT_RANGE;
              end else begin
                dwe    = 1'b1;
                dwaddr = pos_x[AW-1:0];
                dwdata = word;
              end
            end
            ACT_SEARCH: begin
              idx_d   = '0;
              state_d = ST_SRCH;
            end
            ACT_READ: begin
              if (pos_x >= count_x) begin
                status_d = STAT_RANGE;
              end else begin
                ram_re_o    = 1'b1;
                ram_raddr_o = pos_x[AW-1:0];
                rd_sel_d    = 1'b1;
              end
            end
            default: begin
            end
          endcase
        end
      end
      ST_INS: begin
        if (XW'(idx_q) > pos_q) begin
          ram_re_o    = 1'b1;
          ram_raddr_o = idx_m1[AW-1:0];
          wv_d        = 1'b1;
          wa_d        = idx_q[AW-1:0];
          idx_d       = idx_m1;
        end else begin
          state_d = ST_INS_PUT;
        end
      end
      ST_INS_PUT: begin
        dwe     = 1'b1;
        dwaddr  = pos_q[AW-1:0];
        dwdata  = key_q;
        count_d = count_q + 1'b1;
        state_d = ST_DONE;
      end
      ST_DEL: begin
        if (idx_p1 < count_q) begin
          ram_re_o    = 1'b1;
          ram_raddr_o = idx_p1[AW-1:0];
          wv_d        = 1'b1;
          wa_d        = idx_q[AW-1:0];
          idx_d       = idx_p1;
        end else begin
          count_d = count_q - 1'b1;
          state_d = ST_DONE;
        end
      end
      ST_SRCH: begin
        if (cmp_v_q && (ram_rdata_i == key_q)) begin
          found_d = 1'b1;
          fpos_d  = cmp_idx_q;
          state_d = ST_DONE;
        end else if (idx_q < count_q) begin
          ram_re_o    = 1'b1;
          ram_raddr_o = idx_q[AW-1:0];
          cmp_v_d     = 1'b1;
          cmp_idx_d   = idx_q;
          idx_d       = idx_p1;
        end else begin
          state_d = ST_DONE;
        end
      end
      ST_DONE: begin
        res_valid_o = 1'b1;
        if (res_ready_i) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  assign ram_we_o    = wv_q | dwe;
  assign ram_waddr_o = wv_q ? wa_q : dwaddr;
  assign ram_wdata_o = wv_q ? ram_rdata_i : dwdata;

  assign res_o.status         = status_q;
  assign res_o.entry_count    = COUNT_BITS'(count_q);
  assign res_o.found          = found_q;
  assign res_o.found_position = POS_BITS'(fpos_q);
  assign res_o.read_word      = rd_sel_q ? rd_ext[VALUE_BITS-1:0] : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      count_q <= '0;
      wv_q    <= 1'b0;
      cmp_v_q <= 1'b0;
    end else begin
      state_q <= state_d;
      count_q <= count_d;
      wv_q    <= wv_d;
      cmp_v_q <= cmp_v_d;
    end
  end

  always_ff @(posedge clk_i) begin
    idx_q     <= idx_d;
    pos_q     <= pos_d;
    key_q     <= key_d;
    wa_q      <= wa_d;
    cmp_idx_q <= cmp_idx_d;
    status_q  <= status_d;
    found_q   <= found_d;
    fpos_q    <= fpos_d;
    rd_sel_q  <= rd_sel_d;
  end

`ifndef SYNTHESIS
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CW'(DEPTH))
    else $error("entry count above depth");

  a_count_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !$stable(count_q) |-> (count_q == CW'($past(count_q) + 1'b1)) ||
                          (count_q == CW'($past(count_q) - 1'b1)))
    else $error("entry count moved by more than one");

  a_shift_write: assert property (@(posedge clk_i) disable iff (!rst_ni)
    wv_q |-> (state_q == ST_INS) || (state_q == ST_DEL))
    else $error("shift write outside a shift");

  a_write_owner: assert property (@(posedge clk_i) disable iff (!rst_ni)
    wv_q |-> !dwe)
    else $error("shift write collides with a direct write");

  a_done_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_DONE) && !res_ready_i |=> (state_q == ST_DONE) && $stable(count_q))
    else $error("result dropped while held");
`endif

endmodule

// ----- rtl/ordered_array_list_engine_unit.sv -----
// Top level of the ordered array list engine: sequencer, entry store, result register.
//
//   channel | direction | signals                                        | accepted when
//   --------+-----------+------------------------------------------------+--------------------
//   in      | input     | action_i, position_i, value_i                  | in_valid_i & !in_stall_o
//   out     | output    | status_o, entry_count_o, found_o,              | out_valid_o & !out_stall_i
//           |           | found_position_o, read_word_o                  |
//
// Append, overwrite and read touch one entry; insert and delete shift the list tail.
// Search reads the store once per entry, from position 0 up to the first hit or the end.
// Reset clears the count; the store holds no valid data until written.
// Hold a finished beat in the output register; the sequencer takes the next item meanwhile.
// An output stall adds cycles only while the output register is still full.
module ordered_array_list_engine_unit
  import oal_pkg::*;
#(
  parameter int unsigned DEPTH     = 1024,
  parameter int unsigned WORD_BITS = 32
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  output logic                         in_stall_o,
  input  logic [ACTION_BITS-1:0]       action_i,
  input  logic [POS_BITS-1:0]          position_i,
  input  logic signed [VALUE_BITS-1:0] value_i,
  output logic                         out_valid_o,
  input  logic                         out_stall_i,
  output logic [STATUS_BITS-1:0]       status_o,
  output logic [COUNT_BITS-1:0]        entry_count_o,
  output logic                         found_o,
  output logic [POS_BITS-1:0]          found_position_o,
  output logic signed [VALUE_BITS-1:0] read_word_o
);

  localparam int unsigned AW = $clog2(DEPTH);
  localparam int unsigned CW = $clog2(DEPTH + 1);

  logic                 in_ready;
  logic                 res_valid;
  logic                 res_ready;
  oal_result_t          res;
  logic                 ram_we;
  logic [AW-1:0]        ram_waddr;
  logic [WORD_BITS-1:0] ram_wdata;
  logic                 ram_re;
  logic [AW-1:0]        ram_raddr;
  logic [WORD_BITS-1:0] ram_rdata;

  logic                 out_valid_q, out_valid_d;
  oal_result_t          out_q;

  oal_ctrl #(
    .DEPTH     (DEPTH),
    .WORD_BITS (WORD_BITS),
    .AW        (AW),
    .CW        (CW)
  ) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready),
    .action_i    (action_i),
    .position_i  (position_i),
    .value_i     (value_i),
    .res_valid_o (res_valid),
    .res_ready_i (res_ready),
    .res_o       (res),
    .ram_we_o    (ram_we),
    .ram_waddr_o (ram_waddr),
    .ram_wdata_o (ram_wdata),
    .ram_re_o    (ram_re),
    .ram_raddr_o (ram_raddr),
    .ram_rdata_i (ram_rdata)
  );

  oal_ram #(
    .DEPTH     (DEPTH),
    .WORD_BITS (WORD_BITS),
    .AW        (AW)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  assign in_stall_o = !in_ready;
  assign res_ready  = !out_valid_q || !out_stall_i;

  always_comb begin
    if (res_valid && res_ready) begin
      out_valid_d = 1'b1;
    end else if (out_stall_i) begin
      out_valid_d = out_valid_q;
    end else begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_valid && res_ready) begin
      out_q <= res;
    end
  end

  assign out_valid_o      = out_valid_q;
  assign status_o         = out_q.status;
  assign entry_count_o    = out_q.entry_count;
  assign found_o          = out_q.found;
  assign found_position_o = out_q.found_position;
  assign read_word_o      = out_q.read_word;

endmodule

// ----- tb/ordered_array_list_engine_unit_test.sv -----
// Self-checking testbench for the ordered array list engine: random and directed list actions.
`timescale 1ns / 100ps

module ordered_array_list_engine_unit_test;
  import oal_pkg::*;

  localparam int unsigned LIST_DEPTH   = 1024;
  localparam int unsigned RANDOM_ITEMS = 540;
  localparam int unsigned TAIL_ITEMS   = 60;
  localparam int unsigned DRAIN_CYCLES = 1100;

  localparam logic [ACTION_BITS-1:0] ACT_RSVD6 = 3'd6;
  localparam logic [ACTION_BITS-1:0] ACT_RSVD7 = 3'd7;

  localparam logic signed [VALUE_BITS-1:0] MARK_FIRST = 32'sh8000_0001;
  localparam logic signed [VALUE_BITS-1:0] MARK_LAST  = 32'sh7fff_fffe;

  typedef struct packed {
    logic [ACTION_BITS-1:0]       action;
    logic [POS_BITS-1:0]          position;
    logic signed [VALUE_BITS-1:0] value;
    logic                         drain_first;
  } list_req_t;

  logic                         clk_i = 1'b0;
  logic                         rst_ni = 1'b0;
  logic                         in_valid_i = 1'b0;
  logic                         in_stall_o;
  logic [ACTION_BITS-1:0]       action_i = '0;
  logic [POS_BITS-1:0]          position_i = '0;
  logic signed [VALUE_BITS-1:0] value_i = '0;
  logic                         out_valid_o;
  logic                         out_stall_i = 1'b0;
  logic [STATUS_BITS-1:0]       status_o;
  logic [COUNT_BITS-1:0]        entry_count_o;
  logic                         found_o;
  logic [POS_BITS-1:0]          found_position_o;
  logic signed [VALUE_BITS-1:0] read_word_o;

  list_req_t   list_requests[$];
  oal_result_t list_replies[$];

  logic signed [VALUE_BITS-1:0] list_words [LIST_DEPTH];
  int unsigned                  list_count = 0;
  int unsigned                  plan_count = 0;
  int unsigned                  reply_errors = 0;

  int  send_gap = 0;
  int  stall_left = 0;
  bit  send_idle_on = 1'b1;
  bit  recv_idle_on = 1'b1;

  oal_result_t got_beat;
  oal_result_t want_beat;

  ordered_array_list_engine_unit #(
    .DEPTH    (LIST_DEPTH),
    .WORD_BITS(VALUE_BITS)
  ) DUT (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid_i),
    .in_stall_o      (in_stall_o),
    .action_i        (action_i),
    .position_i      (position_i),
    .value_i         (value_i),
    .out_valid_o     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .status_o        (status_o),
    .entry_count_o   (entry_count_o),
    .found_o         (found_o),
    .found_position_o(found_position_o),
    .read_word_o     (read_word_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  function automatic oal_result_t list_apply(input logic [ACTION_BITS-1:0] act,
                                             input logic [POS_BITS-1:0] pos_in,
                                             input logic signed [VALUE_BITS-1:0] word);
    oal_result_t res;
    int unsigned pos;
    int unsigned k;
    res = '0;
    pos = pos_in;
    case (act)
      ACT_APPEND: begin
        if (list_count >= LIST_DEPTH) begin
          res.status = STAT_FULL;
        end else begin
          list_words[list_count] = word;
          list_count++;
        end
      end
      ACT_INSERT: begin
        if (list_count >= LIST_DEPTH) begin
          res.status = STAT_FULL;
        end else if (pos > list_count) begin
          res.status = STAT_RANGE;
        end else begin
          for (k = list_count; k > pos; k--) list_words[k] = list_words[k-1];
          list_words[pos] = word;
          list_count++;
        end
      end
      ACT_DELETE: begin
        if (pos >= list_count) begin
          res.status = STAT_RANGE;
        end else begin
          for (k = pos; k + 1 < list_count; k++) list_words[k] = list_words[k+1];
          list_count--;
        end
      end
      ACT_OVERWRITE: begin
        if (pos >= list_count) res.status = STAT_RANGE;
        else list_words[pos] = word;
      end
      ACT_SEARCH: begin
        for (k = 0; k < list_count; k++) begin
          if (list_words[k] == word) begin
            res.found = 1'b1;
            res.found_position = POS_BITS'(k);
            break;
          end
        end
      end
      ACT_READ: begin
        if (pos >= list_count) res.status = STAT_RANGE;
        else res.read_word = list_words[pos];
      end
      default: begin
      end
    endcase
    res.entry_count = COUNT_BITS'(list_count);
    return res;
  endfunction

  function automatic logic signed [VALUE_BITS-1:0] pick_value();
    logic signed [VALUE_BITS-1:0] v;
    case ($urandom_range(0, 5))
      0: v = 32'sh8000_0000;
      1: v = 32'sh7fff_ffff;
      2, 3: v = 32'($urandom_range(0, 5)) - 32'd2;
      default: v = $urandom;
    endcase
    return v;
  endfunction

  function automatic int unsigned pick_position(input logic [ACTION_BITS-1:0] act,
                                                input int unsigned cnt);
    int unsigned pos;
    int unsigned r;
    r = $urandom_range(0, 9);
    if (r == 0) pos = $urandom_range(0, LIST_DEPTH - 1);
    else if (r == 1) pos = cnt + $urandom_range(0, 1);
    else if (act == ACT_INSERT) pos = $urandom_range(0, cnt);
    else if (cnt == 0) pos = 0;
    else pos = $urandom_range(0, cnt - 1);
    if (pos > LIST_DEPTH - 1) pos = LIST_DEPTH - 1;
    return pos;
  endfunction

  task automatic queue_item(input logic [ACTION_BITS-1:0] act, input int unsigned pos,
                            input logic signed [VALUE_BITS-1:0] word, input bit hold);
    list_req_t req;
    req.action      = act;
    req.position    = POS_BITS'(pos);
    req.value       = word;
    req.drain_first = hold;
    list_requests.push_back(req);
    case (act)
      ACT_APPEND: if (plan_count < LIST_DEPTH) plan_count++;
      ACT_INSERT: if (plan_count < LIST_DEPTH && pos <= plan_count) plan_count++;
      ACT_DELETE: if (pos < plan_count) plan_count--;
      default: begin
      end
    endcase
  endtask

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_valid_i && !in_stall_o) begin
        list_replies.push_back(list_apply(action_i, position_i, value_i));
      end
      if ($urandom_range(0, 99) == 0) send_idle_on <= !send_idle_on;
      if (!in_valid_i || !in_stall_o) begin
        if (send_gap != 0) begin
          send_gap <= send_gap - 1;
          in_valid_i <= 1'b0;
        end else if (send_idle_on && list_requests.size() >= TAIL_ITEMS &&
                     $urandom_range(0, 5) == 0) begin
          send_gap <= $urandom_range(0, 12);
          in_valid_i <= 1'b0;
        end else if (list_requests.size() != 0 &&
                     !(list_requests[0].drain_first && list_replies.size() != 0)) begin
          action_i   <= list_requests[0].action;
          position_i <= list_requests[0].position;
          value_i    <= list_requests[0].value;
          in_valid_i <= 1'b1;
          void'(list_requests.pop_front());
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (out_valid_o && !out_stall_i) begin
        got_beat.status         = oal_status_e'(status_o);
        got_beat.entry_count    = entry_count_o;
        got_beat.found          = found_o;
        got_beat.found_position = found_position_o;
        got_beat.read_word      = read_word_o;
        if (list_replies.size() == 0) begin
          reply_errors++;
          if (reply_errors <= 10)
            $display("unexpected result beat: status %0d count %0d found %0b pos %0d word %0d",
                     got_beat.status, got_beat.entry_count, got_beat.found,
                     got_beat.found_position, got_beat.read_word);
        end else begin
          want_beat = list_replies.pop_front();
          if (got_beat.status !== want_beat.status ||
              got_beat.entry_count !== want_beat.entry_count ||
              got_beat.found !== want_beat.found ||
              got_beat.found_position !== want_beat.found_position ||
              got_beat.read_word !== want_beat.read_word) begin
            reply_errors++;
            if (reply_errors <= 10)
              $display({"result mismatch: expected status %0d count %0d found %0b pos %0d ",
                        "word %0d, got status %0d count %0d found %0b pos %0d word %0d"},
                       want_beat.status, want_beat.entry_count, want_beat.found,
                       want_beat.found_position, want_beat.read_word,
                       got_beat.status, got_beat.entry_count, got_beat.found,
                       got_beat.found_position, got_beat.read_word);
          end
        end
      end
      if ($urandom_range(0, 99) == 0) recv_idle_on <= !recv_idle_on;
      if (stall_left != 0) begin
        stall_left <= stall_left - 1;
        out_stall_i <= 1'b1;
      end else if (recv_idle_on && list_requests.size() >= TAIL_ITEMS &&
                   $urandom_range(0, 5) == 0) begin
        stall_left <= $urandom_range(0, 12);
        out_stall_i <= 1'b1;
      end else begin
        out_stall_i <= 1'b0;
      end
    end
  end

  initial begin : stimulus
    int unsigned n;
    int unsigned r;
    logic [ACTION_BITS-1:0] act;

    queue_item(ACT_READ, 0, 32'sd0, 1'b0);
    queue_item(ACT_DELETE, 0, 32'sd0, 1'b0);
    queue_item(ACT_OVERWRITE, 0, 32'sd7, 1'b0);
    queue_item(ACT_SEARCH, 0, 32'sd0, 1'b0);
    queue_item(ACT_INSERT, 1, 32'sd3, 1'b0);
    queue_item(ACT_INSERT, 0, 32'sh8000_0000, 1'b0);
    queue_item(ACT_APPEND, 0, 32'sh7fff_ffff, 1'b0);
    queue_item(ACT_INSERT, 2, -32'sd1, 1'b0);
    queue_item(ACT_INSERT, 1, 32'sd0, 1'b0);
    queue_item(ACT_APPEND, 1023, 32'sd1, 1'b0);
    queue_item(ACT_SEARCH, 0, -32'sd1, 1'b0);
    queue_item(ACT_SEARCH, 0, 32'sh8000_0000, 1'b0);
    queue_item(ACT_SEARCH, 0, 32'sd5, 1'b0);
    queue_item(ACT_OVERWRITE, 2, 32'sh5555_5555, 1'b0);
    queue_item(ACT_OVERWRITE, 5, 32'sh2aaa_aaaa, 1'b0);
    queue_item(ACT_READ, 2, 32'sd0, 1'b0);
    queue_item(ACT_READ, 1023, 32'sd0, 1'b0);
    queue_item(ACT_DELETE, 0, 32'sd0, 1'b0);
    queue_item(ACT_DELETE, 3, 32'sd0, 1'b0);
    queue_item(ACT_DELETE, 1023, 32'sd0, 1'b0);
    queue_item(ACT_RSVD6, 0, 32'sd0, 1'b1);
    queue_item(ACT_RSVD7, 1023, -32'sd1, 1'b0);
    queue_item(ACT_INSERT, 1023, 32'sd9, 1'b0);
    queue_item(ACT_READ, 0, 32'sd0, 1'b0);
    queue_item(ACT_SEARCH, 0, 32'sd0, 1'b0);

    for (n = 0; n < RANDOM_ITEMS; n++) begin
      r = $urandom_range(0, 99);
      if (plan_count > 80 && r < 40) act = ACT_DELETE;
      else if (r < 4) act = ($urandom_range(0, 1) != 0) ? ACT_RSVD7 : ACT_RSVD6;
      else if (r < 24) act = ACT_APPEND;
      else if (r < 42) act = ACT_INSERT;
      else if (r < 60) act = ACT_DELETE;
      else if (r < 72) act = ACT_OVERWRITE;
      else if (r < 86) act = ACT_SEARCH;
      else act = ACT_READ;
      queue_item(act, pick_position(act, plan_count), pick_value(),
                 $urandom_range(0, 49) == 0);
    end

    queue_item(ACT_APPEND, 0, pick_value(), 1'b1);
    queue_item(ACT_INSERT, 0, pick_value(), 1'b0);
    queue_item(ACT_INSERT, 1023, pick_value(), 1'b0);
    queue_item(ACT_READ, 1023, 32'sd0, 1'b0);
    queue_item(ACT_OVERWRITE, 1023, MARK_LAST, 1'b0);
    queue_item(ACT_SEARCH, 0, MARK_LAST, 1'b0);
    queue_item(ACT_DELETE, 1023, 32'sd0, 1'b0);
    queue_item(ACT_READ, 1023, 32'sd0, 1'b0);
    queue_item(ACT_INSERT, 0, MARK_FIRST, 1'b0);
    queue_item(ACT_SEARCH, 0, MARK_FIRST, 1'b0);
    queue_item(ACT_READ, 0, 32'sd0, 1'b0);
    queue_item(ACT_DELETE, 0, 32'sd0, 1'b0);
    queue_item(ACT_INSERT, 1023, pick_value(), 1'b0);
    queue_item(ACT_APPEND, 0, pick_value(), 1'b0);
    queue_item(ACT_DELETE, 512, 32'sd0, 1'b0);
    queue_item(ACT_SEARCH, 0, $urandom, 1'b0);
    queue_item(ACT_READ, 511, 32'sd0, 1'b0);

    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    while (list_requests.size() != 0 || in_valid_i) @(posedge clk_i);
    while (list_replies.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (reply_errors == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

  initial begin
    #40_000_000;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule
